[src/irpld_pkg.sv]
// shared constants, types and helpers for the ir pulse length byte decoder
package irpld_pkg;

  // fixed field widths
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned CODE_W    = 4;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIMIT = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] SHORT_LIMIT_RST   = 8'd3;
  localparam logic [CFG_W-1:0] MARK_LIMIT_RST    = 8'd5;
  localparam logic [CFG_W-1:0] SILENCE_LIMIT_RST = 8'd9;

  // parameter defaults
  localparam int unsigned FRAME_BITS_DEF = 8;
  localparam int unsigned RUN_WIDTH_DEF  = 8;

  // offset taken off the byte before the code nibble is cut out
  localparam logic [DATA_W-1:0] CODE_OFFSET = 8'd3;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data_byte;
    logic [CODE_W-1:0] code_nibble;
  } result_t;

  // bits 5:2 of (d - 3) in two's complement equal the arithmetic shift by 2,
  // which is all ones for bytes below the offset
  function automatic logic [CODE_W-1:0] code_of(input logic [DATA_W-1:0] d);
    logic [DATA_W-1:0] diff;
    diff = d - CODE_OFFSET;
    return diff[CODE_W+1:2];
  endfunction

endpackage

[src/ir_pulse_length_byte_decoder.sv]
// Decodes a sampled infrared receiver line into bytes from the lengths of its
// level runs. Each input item is one line sample; the first sample after reset
// sets the idle level. An edge while idle opens a frame, a run between
// short_limit and mark_limit before an edge sets the current bit and skips the
// following edge, and a long idle-level run steps the bit position on every
// tick. After FRAME_BITS positions the next sample is consumed to emit one
// item holding the byte and its code nibble. The block takes one sample per
// cycle while no emit is held back: samples pass an input register, a state
// update and a result register. A sample that would emit waits only while
// the result register is still occupied.
module ir_pulse_length_byte_decoder #(
  parameter int unsigned FRAME_BITS = irpld_pkg::FRAME_BITS_DEF,
  parameter int unsigned RUN_WIDTH  = irpld_pkg::RUN_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [0] ir_level, [7:1] zero
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,   // [7:0] data_byte, [11:8] code_nibble
  input  logic                            cfg_we,
  input  logic [irpld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irpld_pkg::CFG_W-1:0]     cfg_data
);

  logic                          take;
  logic                          held_valid;
  logic                          held_level;
  logic                          out_free;
  irpld_pkg::result_t            result;
  logic [irpld_pkg::DATA_W-1:0]  data_byte;
  logic [irpld_pkg::CODE_W-1:0]  code_nibble;

  irpld_in u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_level   (s_tdata[0]),
    .take       (take),
    .held_valid (held_valid),
    .held_level (held_level)
  );

  irpld_core #(
    .FRAME_BITS (FRAME_BITS),
    .RUN_WIDTH  (RUN_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .held_valid (held_valid),
    .held_level (held_level),
    .out_free   (out_free),
    .take       (take),
    .result     (result)
  );

  irpld_out u_out (
    .clk         (clk),
    .rst         (rst),
    .result      (result),
    .out_free    (out_free),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .data_byte   (data_byte),
    .code_nibble (code_nibble)
  );

  assign m_tdata = {4'b0000, code_nibble, data_byte};

endmodule

[src/irpld_in.sv]
// input register holding one line sample item
module irpld_in (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_level,
  input  logic take,
  output logic held_valid,
  output logic held_level
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_level <= in_level;
    end
  end

endmodule

[src/irpld_core.sv]
// decoder state, limit registers and per-sample update
module irpld_core #(
  parameter int unsigned FRAME_BITS = irpld_pkg::FRAME_BITS_DEF,
  parameter int unsigned RUN_WIDTH  = irpld_pkg::RUN_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [irpld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irpld_pkg::CFG_W-1:0]      cfg_data,
  input  logic                             held_valid,
  input  logic                             held_level,
  input  logic                             out_free,
  output logic                             take,
  output irpld_pkg::result_t               result
);

  localparam int unsigned BP_W  = $clog2(FRAME_BITS + 1);
  localparam int unsigned CMP_W = (RUN_WIDTH > irpld_pkg::CFG_W) ? RUN_WIDTH
                                                                 : irpld_pkg::CFG_W;

  logic [irpld_pkg::CFG_W-1:0] short_limit;
  logic [irpld_pkg::CFG_W-1:0] mark_limit;
  logic [irpld_pkg::CFG_W-1:0] silence_limit;

  logic                          seen_first, seen_first_next;
  logic                          prev_level, prev_level_next;
  logic                          idle_level, idle_level_next;
  logic [RUN_WIDTH-1:0]          run_length, run_length_next;
  logic                          receiving, receiving_next;
  logic [BP_W-1:0]               bit_position, bit_position_next;
  logic                          skip_edge, skip_edge_next;
  logic [irpld_pkg::DATA_W-1:0]  shift_data, shift_data_next;

  logic                 emit_now;
  logic                 prev_eff;
  logic                 idle_eff;
  logic [CMP_W-1:0]     run_cmp;
  logic [CMP_W-1:0]     run_inc_cmp;
  logic [RUN_WIDTH-1:0] run_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_limit   <= irpld_pkg::SHORT_LIMIT_RST;
      mark_limit    <= irpld_pkg::MARK_LIMIT_RST;
      silence_limit <= irpld_pkg::SILENCE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        irpld_pkg::REG_SHORT_LIMIT:   short_limit   <= cfg_data;
        irpld_pkg::REG_MARK_LIMIT:    mark_limit    <= cfg_data;
        irpld_pkg::REG_SILENCE_LIMIT: silence_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign emit_now = receiving && (bit_position >= BP_W'(FRAME_BITS));
  // a sample that would emit waits until the result register is free
  assign take     = held_valid && (!emit_now || out_free);

  // the very first sample fixes both the previous and the idle level
  assign prev_eff    = seen_first ? prev_level : held_level;
  assign idle_eff    = seen_first ? idle_level : held_level;
  assign run_inc     = (run_length == {RUN_WIDTH{1'b1}}) ? run_length
                                                         : run_length + 1'b1;
  assign run_cmp     = CMP_W'(run_length);
  assign run_inc_cmp = CMP_W'(run_inc);

  assign result.valid       = take && emit_now;
  assign result.data_byte   = shift_data;
  assign result.code_nibble = irpld_pkg::code_of(shift_data);

  always_comb begin
    seen_first_next   = seen_first;
    prev_level_next   = prev_level;
    idle_level_next   = idle_level;
    run_length_next   = run_length;
    receiving_next    = receiving;
    bit_position_next = bit_position;
    skip_edge_next    = skip_edge;
    shift_data_next   = shift_data;
    if (take) begin
      seen_first_next = 1'b1;
      prev_level_next = prev_eff;
      idle_level_next = idle_eff;
      if (emit_now) begin
        receiving_next    = 1'b0;
        bit_position_next = '0;
        skip_edge_next    = 1'b0;
      end else if (held_level == prev_eff) begin
        run_length_next = run_inc;
        // long silence at the idle level steps the position every tick
        if (receiving && (held_level == idle_eff) &&
            (run_inc_cmp >= CMP_W'(silence_limit))) begin
          bit_position_next = bit_position + 1'b1;
        end
      end else begin
        if (!skip_edge) begin
          if (!receiving) begin
            receiving_next    = 1'b1;
            bit_position_next = '0;
            shift_data_next   = '0;
          end else begin
            if ((run_cmp >= CMP_W'(short_limit)) && (run_cmp <= CMP_W'(mark_limit))) begin
              // positions past the byte shift the one out of range
              shift_data_next = shift_data | (irpld_pkg::DATA_W'(1) << bit_position);
              skip_edge_next  = 1'b1;
            end
            bit_position_next = bit_position + 1'b1;
          end
        end else begin
          skip_edge_next = 1'b0;
        end
        run_length_next = RUN_WIDTH'(1);
        prev_level_next = held_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_first   <= 1'b0;
      prev_level   <= 1'b0;
      idle_level   <= 1'b0;
      run_length   <= '0;
      receiving    <= 1'b0;
      bit_position <= '0;
      skip_edge    <= 1'b0;
      shift_data   <= '0;
    end else begin
      seen_first   <= seen_first_next;
      prev_level   <= prev_level_next;
      idle_level   <= idle_level_next;
      run_length   <= run_length_next;
      receiving    <= receiving_next;
      bit_position <= bit_position_next;
      skip_edge    <= skip_edge_next;
      shift_data   <= shift_data_next;
    end
  end

endmodule

[src/irpld_out.sv]
// result register on the output stream
module irpld_out (
  input  logic                          clk,
  input  logic                          rst,
  input  irpld_pkg::result_t            result,
  output logic                          out_free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [irpld_pkg::DATA_W-1:0]  data_byte,
  output logic [irpld_pkg::CODE_W-1:0]  code_nibble
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      data_byte   <= result.data_byte;
      code_nibble <= result.code_nibble;
    end
  end

endmodule
